>>> design/phl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// phl_pkg - shared types and constants of the two-level perfect hash lookup
// Sizes of the stores, field widths, operation and register codes, the item
// that travels down the lookup pipeline and the Mersenne-prime fold.
// ----------------------------------------------------------------------------
package phl_pkg;

	// store sizes
	localparam int BUCKETS = 1024;
	localparam int SLOTS   = 8192;
	localparam int BKT_AW  = $clog2(BUCKETS);
	localparam int SLOT_AW = $clog2(SLOTS);

	// field widths
	localparam int OP_W       = 2;
	localparam int IDX_W      = 13;
	localparam int KEY_W      = 31;
	localparam int CAP_W      = 14;
	localparam int BASE_W     = 13;
	localparam int CNT_W      = 11;
	localparam int CFG_W      = 31;
	localparam int REG_IDX_W  = 2;
	localparam int BKT_OUT_W  = 10;
	localparam int SLOT_OUT_W = 13;
	localparam int HASH_W     = 32;

	// remainder unit geometry
	localparam int DVD_W = 31;
	localparam int DSR_W = 14;

	// front queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	localparam logic [HASH_W-1:0] HASH_PRIME = 32'd2147483647;

	// operation codes on the input channel
	localparam logic [OP_W-1:0] OP_BKT_WR  = 2'd0;
	localparam logic [OP_W-1:0] OP_SLOT_WR = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;

	// configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_FIRST_MULT   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_FIRST_ADD    = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_BUCKET_COUNT = 2'd2;

	typedef enum logic [1:0] {
		KIND_NOP,
		KIND_BKT_WR,
		KIND_SLOT_WR,
		KIND_QUERY
	} kind_t;

	// one classified item; descriptor fields are refilled from the store for queries
	typedef struct packed {
		kind_t             kind;
		logic [IDX_W-1:0]  idx;
		logic [KEY_W-1:0]  key;
		logic              ev;
		logic [KEY_W-1:0]  mult;
		logic [KEY_W-1:0]  add;
		logic [CAP_W-1:0]  cap;
		logic [BASE_W-1:0] base;
		logic [BKT_AW-1:0] bkt;
		logic              hit;
	} item_t;

	typedef struct packed {
		logic              present;
		logic [KEY_W-1:0]  mult;
		logic [KEY_W-1:0]  add;
		logic [CAP_W-1:0]  cap;
		logic [BASE_W-1:0] base;
	} bkt_entry_t;

	typedef struct packed {
		logic             filled;
		logic [KEY_W-1:0] key;
	} slot_entry_t;

	// reduce a 32-bit value modulo 2^31-1: fold the top bit, then one subtract
	function automatic logic [DVD_W-1:0] fold_prime(input logic [HASH_W-1:0] t);
		logic [HASH_W-1:0] s;
		s = {1'b0, t[HASH_W-2:0]} + {{(HASH_W-1){1'b0}}, t[HASH_W-1]};
		if (s >= HASH_PRIME) begin
			s = s - HASH_PRIME;
		end
		return s[DVD_W-1:0];
	endfunction

endpackage
`default_nettype wire

>>> design/phl_rem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// phl_rem - pipelined remainder unit
// Restoring remainder of a 31-bit value by a 14-bit divisor, one dividend bit
// per stage; an item rides along with each value.
// ----------------------------------------------------------------------------
module phl_rem (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  wire logic                      in_vld,
	input  wire logic [phl_pkg::DVD_W-1:0] dvd,
	input  wire logic [phl_pkg::DSR_W-1:0] dsr,
	input  wire phl_pkg::item_t            in_item,
	output logic                           out_vld,
	output logic [phl_pkg::DSR_W-1:0]      rem,
	output phl_pkg::item_t                 out_item
);

	logic                      vld_s  [phl_pkg::DVD_W];
	logic [phl_pkg::DVD_W-1:0] dvd_s  [phl_pkg::DVD_W];
	logic [phl_pkg::DSR_W-1:0] dsr_s  [phl_pkg::DVD_W];
	logic [phl_pkg::DSR_W-1:0] rem_s  [phl_pkg::DVD_W];
	phl_pkg::item_t            item_s [phl_pkg::DVD_W];

	logic                      pv   [phl_pkg::DVD_W];
	logic [phl_pkg::DVD_W-1:0] pd   [phl_pkg::DVD_W];
	logic [phl_pkg::DSR_W-1:0] pdsr [phl_pkg::DVD_W];
	logic [phl_pkg::DSR_W-1:0] prem [phl_pkg::DVD_W];
	phl_pkg::item_t            pit  [phl_pkg::DVD_W];
	logic [phl_pkg::DSR_W:0]   part [phl_pkg::DVD_W];
	logic [phl_pkg::DSR_W:0]   diff [phl_pkg::DVD_W];
	logic [phl_pkg::DSR_W-1:0] nrem [phl_pkg::DVD_W];

	// select each stage's inputs: the ports for the first, the previous stage otherwise
	always_comb begin
		for (int i = 0; i < phl_pkg::DVD_W; i++) begin
			if (i == 0) begin
				pv[i]   = in_vld;
				pd[i]   = dvd;
				pdsr[i] = dsr;
				prem[i] = '0;
				pit[i]  = in_item;
			end else begin
				pv[i]   = vld_s[i-1];
				pd[i]   = dvd_s[i-1];
				pdsr[i] = dsr_s[i-1];
				prem[i] = rem_s[i-1];
				pit[i]  = item_s[i-1];
			end
		end
	end

	// shift in one dividend bit and subtract the divisor where it fits
	always_comb begin
		for (int i = 0; i < phl_pkg::DVD_W; i++) begin
			part[i] = {prem[i], pd[i][phl_pkg::DVD_W-1-i]};
			diff[i] = part[i] - {1'b0, pdsr[i]};
			if (part[i] >= {1'b0, pdsr[i]}) begin
				nrem[i] = diff[i][phl_pkg::DSR_W-1:0];
			end else begin
				nrem[i] = part[i][phl_pkg::DSR_W-1:0];
			end
		end
	end

	// advance the valid line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < phl_pkg::DVD_W; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (en) begin
			for (int i = 0; i < phl_pkg::DVD_W; i++) begin
				vld_s[i] <= pv[i];
			end
		end
	end

	// advance the data line
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < phl_pkg::DVD_W; i++) begin
				dvd_s[i]  <= pd[i];
				dsr_s[i]  <= pdsr[i];
				rem_s[i]  <= nrem[i];
				item_s[i] <= pit[i];
			end
		end
	end

	assign out_vld  = vld_s[phl_pkg::DVD_W-1];
	assign rem      = rem_s[phl_pkg::DVD_W-1];
	assign out_item = item_s[phl_pkg::DVD_W-1];

endmodule
`default_nettype wire

>>> design/phl_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// phl_front - input side of the lookup
// Accepts items, classifies them (write, query or no-op, with range checks
// on write indexes) and holds them in a short queue for the lookup pipeline.
// ----------------------------------------------------------------------------
module phl_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [phl_pkg::OP_W-1:0]   op,
	input  wire logic [phl_pkg::IDX_W-1:0]  index,
	input  wire logic [phl_pkg::KEY_W-1:0]  key,
	input  wire logic                       entry_valid,
	input  wire logic [phl_pkg::KEY_W-1:0]  second_mult,
	input  wire logic [phl_pkg::KEY_W-1:0]  second_add,
	input  wire logic [phl_pkg::CAP_W-1:0]  second_capacity,
	input  wire logic [phl_pkg::BASE_W-1:0] second_base,
	input  wire logic                       clear_busy,
	input  wire logic                       pop,
	output logic                            q_valid,
	output phl_pkg::item_t                  q_item
);

	phl_pkg::item_t               queue_q [phl_pkg::QUEUE_DEPTH];
	logic [phl_pkg::QUEUE_AW-1:0] wr_ptr_q;
	logic [phl_pkg::QUEUE_AW-1:0] rd_ptr_q;
	logic [phl_pkg::QUEUE_AW:0]   cnt_q;
	phl_pkg::item_t               cls;
	logic                         push;
	logic                         full;

	// classify the incoming item
	always_comb begin
		cls.idx  = index;
		cls.key  = key;
		cls.ev   = entry_valid;
		cls.mult = second_mult;
		cls.add  = second_add;
		cls.cap  = second_capacity;
		cls.base = second_base;
		cls.bkt  = '0;
		cls.hit  = 1'b0;
		case (op)
			phl_pkg::OP_BKT_WR: begin
				cls.kind = (int'(index) < phl_pkg::BUCKETS) ? phl_pkg::KIND_BKT_WR
					: phl_pkg::KIND_NOP;
			end
			phl_pkg::OP_SLOT_WR: begin
				cls.kind = (int'(index) < phl_pkg::SLOTS) ? phl_pkg::KIND_SLOT_WR
					: phl_pkg::KIND_NOP;
			end
			phl_pkg::OP_QUERY: begin
				cls.kind = phl_pkg::KIND_QUERY;
			end
			default: begin
				cls.kind = phl_pkg::KIND_NOP;
			end
		endcase
	end

	assign full     = (cnt_q == (phl_pkg::QUEUE_AW+1)'(phl_pkg::QUEUE_DEPTH));
	assign in_stall = full || clear_busy;
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != '0);
	assign q_item   = queue_q[rd_ptr_q];

	// queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// store the transfer
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cls;
		end
	end

endmodule
`default_nettype wire

>>> design/phl_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// phl_back - lookup pipeline
// First-level hash, bucket store access, second-level hash, slot store access
// and the result register. Writes are carried out at the same stage where
// queries read, so every item sees the stores as left by the items before it.
// ----------------------------------------------------------------------------
module phl_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [phl_pkg::REG_IDX_W-1:0] cfg_index,
	input  wire logic [phl_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                          q_valid,
	input  wire phl_pkg::item_t                q_item,
	output logic                               pop,
	output logic                               clear_busy,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               found,
	output logic [phl_pkg::BKT_OUT_W-1:0]      bucket_out,
	output logic [phl_pkg::SLOT_OUT_W-1:0]     slot_out
);

	logic                        adv;

	logic [phl_pkg::KEY_W-1:0]   first_mult_q;
	logic [phl_pkg::KEY_W-1:0]   first_add_q;
	logic [phl_pkg::CNT_W-1:0]   bucket_count_q;
	logic [phl_pkg::DSR_W-1:0]   m1;

	logic                        clear_q;
	logic [phl_pkg::SLOT_AW-1:0] clr_cnt_q;

	phl_pkg::bkt_entry_t         bkt_mem  [phl_pkg::BUCKETS];
	phl_pkg::slot_entry_t        slot_mem [phl_pkg::SLOTS];

	logic                        vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	phl_pkg::item_t              item_s1, item_s2, item_s3, item_s4;
	phl_pkg::item_t              item_s5, item_s6, item_s7, item_s8;
	logic [phl_pkg::HASH_W-1:0]  prod_s1, sum_s2, prod_s5, sum_s6;
	logic [phl_pkg::DVD_W-1:0]   res_s3, res_s7;
	logic [2*phl_pkg::KEY_W-1:0] full1, full2;

	logic                        r1_vld, r2_vld;
	logic [phl_pkg::DSR_W-1:0]   r1_rem, r2_rem;
	phl_pkg::item_t              r1_item, r2_item;

	logic [phl_pkg::BKT_AW-1:0]  b_addr;
	phl_pkg::item_t              b_item;
	phl_pkg::bkt_entry_t         desc_s5;
	phl_pkg::item_t              merged;

	logic [phl_pkg::CAP_W:0]     slot_sum;
	logic [phl_pkg::SLOT_AW-1:0] s_addr;
	phl_pkg::slot_entry_t        sd_s8;
	logic [phl_pkg::DSR_W-1:0]   j_s8;

	logic                        hit_now;
	logic                        out_valid_q;
	logic                        found_q;
	logic [phl_pkg::BKT_OUT_W-1:0]  bucket_q;
	logic [phl_pkg::SLOT_OUT_W-1:0] slot_q;

	// the whole pipeline moves unless a finished result is held
	assign adv        = !out_valid_q || !out_stall;
	assign pop        = adv && q_valid;
	assign clear_busy = clear_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_mult_q   <= phl_pkg::KEY_W'(1);
			first_add_q    <= '0;
			bucket_count_q <= phl_pkg::CNT_W'(1);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				phl_pkg::REG_FIRST_MULT:   first_mult_q   <= cfg_data[phl_pkg::KEY_W-1:0];
				phl_pkg::REG_FIRST_ADD:    first_add_q    <= cfg_data[phl_pkg::KEY_W-1:0];
				phl_pkg::REG_BUCKET_COUNT: bucket_count_q <= cfg_data[phl_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// a zero bucket count acts as one
	assign m1 = (bucket_count_q == '0) ? phl_pkg::DSR_W'(1)
		: {{(phl_pkg::DSR_W-phl_pkg::CNT_W){1'b0}}, bucket_count_q};

	// clearing pass over both stores after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q   <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clear_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == phl_pkg::SLOT_AW'(phl_pkg::SLOTS-1)) begin
				clear_q <= 1'b0;
			end
		end
	end

	// valid line of the hash stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= q_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= r1_vld;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= r2_vld;
		end
	end

	assign full1 = q_item.key * first_mult_q;
	assign full2 = merged.key * merged.mult;

	// first-level hash: multiply, add, fold modulo the prime
	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= q_item;
			prod_s1 <= full1[phl_pkg::HASH_W-1:0];
			item_s2 <= item_s1;
			sum_s2  <= prod_s1 + {1'b0, first_add_q};
			item_s3 <= item_s2;
			res_s3  <= phl_pkg::fold_prime(sum_s2);
		end
	end

	phl_rem u_rem1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (vld_s3),
		.dvd      (res_s3),
		.dsr      (m1),
		.in_item  (item_s3),
		.out_vld  (r1_vld),
		.rem      (r1_rem),
		.out_item (r1_item)
	);

	// bucket store address: write index or first-level hash
	always_comb begin
		b_item     = r1_item;
		b_item.bkt = r1_rem[phl_pkg::BKT_AW-1:0];
		b_item.hit = (int'(r1_rem) < phl_pkg::BUCKETS);
		if (r1_item.kind == phl_pkg::KIND_BKT_WR) begin
			b_addr = r1_item.idx[phl_pkg::BKT_AW-1:0];
		end else begin
			b_addr = r1_rem[phl_pkg::BKT_AW-1:0];
		end
	end

	// bucket store write: clearing pass or descriptor write
	always_ff @(posedge clk) begin
		if (clear_q) begin
			if (int'(clr_cnt_q) < phl_pkg::BUCKETS) begin
				bkt_mem[clr_cnt_q[phl_pkg::BKT_AW-1:0]] <= '0;
			end
		end else if (adv && r1_vld && r1_item.kind == phl_pkg::KIND_BKT_WR) begin
			bkt_mem[b_addr] <= '{present: r1_item.ev, mult: r1_item.mult,
				add: r1_item.add, cap: r1_item.cap, base: r1_item.base};
		end
	end

	// bucket store read
	always_ff @(posedge clk) begin
		if (adv) begin
			desc_s5 <= bkt_mem[b_addr];
			item_s4 <= b_item;
		end
	end

	// take the descriptor into the query
	always_comb begin
		merged = item_s4;
		if (item_s4.kind == phl_pkg::KIND_QUERY) begin
			merged.mult = desc_s5.mult;
			merged.add  = desc_s5.add;
			merged.cap  = desc_s5.cap;
			merged.base = desc_s5.base;
			merged.hit  = item_s4.hit && desc_s5.present && (desc_s5.cap != '0);
		end
	end

	// second-level hash: multiply, add, fold modulo the prime
	always_ff @(posedge clk) begin
		if (adv) begin
			item_s5 <= merged;
			prod_s5 <= full2[phl_pkg::HASH_W-1:0];
			item_s6 <= item_s5;
			sum_s6  <= prod_s5 + {1'b0, item_s5.add};
			item_s7 <= item_s6;
			res_s7  <= phl_pkg::fold_prime(sum_s6);
		end
	end

	phl_rem u_rem2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (vld_s7),
		.dvd      (res_s7),
		.dsr      (item_s7.cap),
		.in_item  (item_s7),
		.out_vld  (r2_vld),
		.rem      (r2_rem),
		.out_item (r2_item)
	);

	// slot address: write index or bucket base plus slot, wrapped
	assign slot_sum = {{(phl_pkg::CAP_W+1-phl_pkg::BASE_W){1'b0}}, r2_item.base}
		+ {1'b0, r2_rem};
	always_comb begin
		if (r2_item.kind == phl_pkg::KIND_SLOT_WR) begin
			s_addr = r2_item.idx[phl_pkg::SLOT_AW-1:0];
		end else begin
			s_addr = slot_sum[phl_pkg::SLOT_AW-1:0];
		end
	end

	// slot store write: clearing pass or key write
	always_ff @(posedge clk) begin
		if (clear_q) begin
			slot_mem[clr_cnt_q] <= '0;
		end else if (adv && r2_vld && r2_item.kind == phl_pkg::KIND_SLOT_WR) begin
			slot_mem[s_addr] <= '{filled: r2_item.ev, key: r2_item.key};
		end
	end

	// slot store read
	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s8   <= slot_mem[s_addr];
			item_s8 <= r2_item;
			j_s8    <= r2_rem;
		end
	end

	assign hit_now = vld_s8 && (item_s8.kind == phl_pkg::KIND_QUERY) && item_s8.hit
		&& sd_s8.filled && (sd_s8.key == item_s8.key);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			found_q  <= hit_now;
			bucket_q <= hit_now ? phl_pkg::BKT_OUT_W'(item_s8.bkt) : '0;
			slot_q   <= hit_now ? j_s8[phl_pkg::SLOT_OUT_W-1:0] : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign found      = found_q;
	assign bucket_out = bucket_q;
	assign slot_out   = slot_q;

endmodule
`default_nettype wire

>>> design/two_level_perfect_hash_lookup_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_level_perfect_hash_lookup_top - two-level perfect hash lookup
// Bucket descriptor and slot writes and key queries on one input channel,
// one result per item on the output channel.
//
//   channel  handshake           payload
//   input    in_valid/in_stall   op, index, key, entry_valid, second_*
//   output   out_valid/out_stall found, bucket_out, slot_out
//   config   cfg_wr_en           cfg_index, cfg_data
//
// One item per cycle sustained while out_stall is low. The pipeline holds
// two 31-stage remainder pipelines (one per hash level) plus the store stages.
// After reset a clearing pass (one slot a cycle) holds in_stall high. out_stall
// freezes the lookup pipeline; a 4-entry queue keeps the input side taking
// transfers until it fills.
// ----------------------------------------------------------------------------
module two_level_perfect_hash_lookup_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [phl_pkg::REG_IDX_W-1:0] cfg_index,
	input  wire logic [phl_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [phl_pkg::OP_W-1:0]      op,
	input  wire logic [phl_pkg::IDX_W-1:0]     index,
	input  wire logic [phl_pkg::KEY_W-1:0]     key,
	input  wire logic                          entry_valid,
	input  wire logic [phl_pkg::KEY_W-1:0]     second_mult,
	input  wire logic [phl_pkg::KEY_W-1:0]     second_add,
	input  wire logic [phl_pkg::CAP_W-1:0]     second_capacity,
	input  wire logic [phl_pkg::BASE_W-1:0]    second_base,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               found,
	output logic [phl_pkg::BKT_OUT_W-1:0]      bucket_out,
	output logic [phl_pkg::SLOT_OUT_W-1:0]     slot_out
);

	logic           q_valid;
	phl_pkg::item_t q_item;
	logic           pop;
	logic           clear_busy;

	phl_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.op              (op),
		.index           (index),
		.key             (key),
		.entry_valid     (entry_valid),
		.second_mult     (second_mult),
		.second_add      (second_add),
		.second_capacity (second_capacity),
		.second_base     (second_base),
		.clear_busy      (clear_busy),
		.pop             (pop),
		.q_valid         (q_valid),
		.q_item          (q_item)
	);

	phl_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.pop        (pop),
		.clear_busy (clear_busy),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.found      (found),
		.bucket_out (bucket_out),
		.slot_out   (slot_out)
	);

endmodule
`default_nettype wire

>>> design/phl_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// phl_checker - port-level checks of the perfect hash lookup
// Watches the top level's ports; attached by the bind below.
// ----------------------------------------------------------------------------
module phl_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           in_stall,
	input wire logic                           out_valid,
	input wire logic                           out_stall,
	input wire logic                           found,
	input wire logic [phl_pkg::BKT_OUT_W-1:0]  bucket_out,
	input wire logic [phl_pkg::SLOT_OUT_W-1:0] slot_out
);

	// a held result keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(found) && $stable(bucket_out)
			&& $stable(slot_out))
		else $error("held result changed");

	// a miss or a write reports zero bucket and slot
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> bucket_out == '0 && slot_out == '0)
		else $error("miss with nonzero position");

	// the clearing pass blocks input straight after reset
	a_clear_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> in_stall)
		else $error("input open during clearing");

	// nothing comes out straight after reset
	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !out_valid)
		else $error("result right after reset");

endmodule

bind two_level_perfect_hash_lookup_top phl_checker u_phl_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.found      (found),
	.bucket_out (bucket_out),
	.slot_out   (slot_out)
);
`default_nettype wire
